FILE: rtl/core/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants of the rail fence encipher unit
// Field widths, default sizes and the job descriptor passed from the loading
// side to the emission side.
// ----------------------------------------------------------------------------
package rfe_pkg;

  // Fixed payload widths.
  localparam int BYTE_W     = 8;
  localparam int RAIL_CFG_W = 6;

  // Default sizes for the top-level parameters.
  localparam int DEF_MESSAGE_DEPTH = 64;
  localparam int DEF_MAX_RAILS     = 32;

  // Rail count after reset and the smallest usable rail count.
  localparam logic [RAIL_CFG_W-1:0] RAIL_COUNT_RESET = 6'd3;
  localparam logic [RAIL_CFG_W-1:0] RAIL_COUNT_MIN   = 6'd2;

  // Job fields are sized for the largest legal parameter values
  // (256-byte store, 32 rails); modules use the low bits they need.
  localparam int JOB_CNT_W  = 9;
  localparam int JOB_RAIL_W = 5;

  // One finished message waiting to be emitted.
  typedef struct packed {
    logic                  bank;      // store half that holds the message
    logic [JOB_CNT_W-1:0]  count;     // bytes in the message, at least one
    logic [JOB_RAIL_W-1:0] rails_m1;  // effective rail count minus one
  } rfe_job_t;

endpackage

FILE: rtl/core/rfe_if.sv
// ----------------------------------------------------------------------------
// rfe_if: channel interfaces of the rail fence encipher unit
// Plaintext input, ciphertext output and rail count configuration channels,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface rfe_in_if import rfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_message;

  modport source (output valid, output text_byte, output end_of_message, input ready);
  modport sink   (input valid, input text_byte, input end_of_message, output ready);
endinterface

interface rfe_out_if import rfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] cipher_byte;
  logic              last_out;

  modport source (output valid, output cipher_byte, output last_out, input ready);
  modport sink   (input valid, input cipher_byte, input last_out, output ready);
endinterface

interface rfe_cfg_if import rfe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RAIL_CFG_W-1:0] rail_count;

  modport source (output valid, output rail_count, input ready);
  modport sink   (input valid, input rail_count, output ready);
endinterface

FILE: rtl/core/rail_fence_encipher_unit.sv
// ----------------------------------------------------------------------------
// rail_fence_encipher_unit: rail fence cipher encoder
// Collects a plaintext message and emits it as rail-major ciphertext.
// ----------------------------------------------------------------------------
// Usage:
//   text_in takes one plaintext byte per transaction; end_of_message on the
//   last byte closes the message. Bytes past MESSAGE_DEPTH are dropped, but
//   an end mark still closes the message. cipher_out gives one ciphertext
//   byte per transaction, rail 0 first, with last_out on the final byte.
//   cfg writes the rail count (values below 2 act as 2, above MAX_RAILS as
//   MAX_RAILS); it is sampled when the end-of-message transaction is taken.
// Timing:
//   Loading takes one byte per cycle. The store has two halves, so a new
//   message loads while the previous one is emitted; input stalls only when
//   both halves hold messages. When the emitter is free, the job passes
//   through the job queue and the emitter's job registers, and the first
//   ciphertext byte is then read into the read register. Emission gives one
//   byte per cycle while the receiver takes them, pausing at each rail change.
// Reset and stalls:
//   rst clears all control state and sets the rail count to 3; no clearing
//   pass is run. When the receiver stalls, the current byte is held in the
//   read register and emission pauses.
// ----------------------------------------------------------------------------
module rail_fence_encipher_unit import rfe_pkg::*; #(
  parameter int MESSAGE_DEPTH = DEF_MESSAGE_DEPTH,
  parameter int MAX_RAILS     = DEF_MAX_RAILS
) (
  input  logic      clk,
  input  logic      rst,
  rfe_in_if.sink    text_in,
  rfe_out_if.source cipher_out,
  rfe_cfg_if.sink   cfg
);

  localparam int AW        = $clog2(MESSAGE_DEPTH);
  localparam int RAM_DEPTH = 2 * (2 ** AW);

  logic              wr_en;
  logic [AW:0]       wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW:0]       rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              push;
  rfe_job_t          push_job;
  logic              pop;
  logic              job_valid;
  rfe_job_t          head_job;
  logic              job_done;

  // Loading side.
  rfe_front #(
    .MESSAGE_DEPTH (MESSAGE_DEPTH),
    .MAX_RAILS     (MAX_RAILS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .cfg      (cfg),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_job (push_job),
    .job_done (job_done)
  );

  // Finished messages waiting for emission.
  rfe_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .job_valid (job_valid),
    .head_job  (head_job)
  );

  // Two-half message store.
  rfe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Emission side.
  rfe_back #(
    .MESSAGE_DEPTH (MESSAGE_DEPTH),
    .MAX_RAILS     (MAX_RAILS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .head_job   (head_job),
    .pop        (pop),
    .job_done   (job_done),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .cipher_out (cipher_out)
  );

endmodule

FILE: rtl/core/rfe_ram.sv
// ----------------------------------------------------------------------------
// rfe_ram: generic simple dual-port RAM
// One write port, one read port with registered read data that holds its
// value while no read is enabled.
// ----------------------------------------------------------------------------
module rfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/rfe_job_queue.sv
// ----------------------------------------------------------------------------
// rfe_job_queue: two-entry queue of message jobs
// Holds finished messages between the loading side and the emission side.
// ----------------------------------------------------------------------------
module rfe_job_queue import rfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rfe_job_t push_job,
  input  logic     pop,
  output logic     job_valid,
  output rfe_job_t head_job
);

  rfe_job_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign job_valid = (fill != 2'd0);
  assign head_job  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/core/rfe_front.sv
// ----------------------------------------------------------------------------
// rfe_front: message loading side
// Takes plaintext transactions into the current store half, holds the rail
// count register and hands each finished message to the job queue.
// ----------------------------------------------------------------------------
module rfe_front import rfe_pkg::*; #(
  parameter int MESSAGE_DEPTH = DEF_MESSAGE_DEPTH,
  parameter int MAX_RAILS     = DEF_MAX_RAILS,
  localparam int AW           = $clog2(MESSAGE_DEPTH),
  localparam int CW           = $clog2(MESSAGE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  rfe_in_if.sink            text_in,
  rfe_cfg_if.sink           cfg,
  output logic              wr_en,
  output logic [AW:0]       wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              push,
  output rfe_job_t          push_job,
  input  logic              job_done
);

  logic [RAIL_CFG_W-1:0] rail_count;
  logic [RAIL_CFG_W-1:0] rails_eff;
  logic [CW-1:0]         byte_count;
  logic [CW-1:0]         byte_count_next;
  logic                  bank;
  logic [1:0]            jobs_open;
  logic                  has_room;
  logic                  take;

  // Both store halves busy means the current half still holds a message
  // that is waiting or being emitted.
  assign text_in.ready = (jobs_open != 2'd2);
  assign take          = text_in.valid && text_in.ready;
  assign cfg.ready     = 1'b1;

  // Store the byte while there is room; extra bytes are dropped.
  assign has_room        = (byte_count < CW'(MESSAGE_DEPTH));
  assign wr_en           = take && has_room;
  assign wr_addr         = {bank, byte_count[AW-1:0]};
  assign wr_data         = text_in.text_byte;
  assign byte_count_next = has_room ? byte_count + CW'(1) : byte_count;

  // Clamp the rail count into the legal range.
  always_comb begin
    priority if (rail_count < RAIL_COUNT_MIN) begin
      rails_eff = RAIL_COUNT_MIN;
    end else if (rail_count > RAIL_CFG_W'(MAX_RAILS)) begin
      rails_eff = RAIL_CFG_W'(MAX_RAILS);
    end else begin
      rails_eff = rail_count;
    end
  end

  // Job handed over with the end-of-message transaction.
  assign push              = take && text_in.end_of_message;
  assign push_job.bank     = bank;
  assign push_job.count    = JOB_CNT_W'(byte_count_next);
  assign push_job.rails_m1 = JOB_RAIL_W'(rails_eff - RAIL_CFG_W'(1));

  // Rail count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count <= RAIL_COUNT_RESET;
    end else if (cfg.valid) begin
      rail_count <= cfg.rail_count;
    end
  end

  // Loading counter, store half select and open job count.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      bank       <= 1'b0;
      jobs_open  <= 2'd0;
    end else begin
      if (push) begin
        byte_count <= '0;
        bank       <= ~bank;
      end else if (take) begin
        byte_count <= byte_count_next;
      end
      unique case ({push, job_done})
        2'b10:   jobs_open <= jobs_open + 2'd1;
        2'b01:   jobs_open <= jobs_open - 2'd1;
        default: jobs_open <= jobs_open;
      endcase
    end
  end

endmodule

FILE: rtl/core/rfe_back.sv
// ----------------------------------------------------------------------------
// rfe_back: ciphertext emission side
// Walks each rail of a queued message, jumping straight from one position
// of the rail to the next, and, unless the receiver stalls or a rail ends,
// reads one stored byte per cycle into the output register.
// ----------------------------------------------------------------------------
module rfe_back import rfe_pkg::*; #(
  parameter int MESSAGE_DEPTH = DEF_MESSAGE_DEPTH,
  parameter int MAX_RAILS     = DEF_MAX_RAILS,
  localparam int AW           = $clog2(MESSAGE_DEPTH),
  localparam int CW           = $clog2(MESSAGE_DEPTH + 1),
  localparam int RW           = $clog2(MAX_RAILS),
  localparam int PW           = $clog2(MESSAGE_DEPTH + 2 * MAX_RAILS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  rfe_job_t          head_job,
  output logic              pop,
  output logic              job_done,
  output logic              rd_en,
  output logic [AW:0]       rd_addr,
  input  logic [BYTE_W-1:0] rd_data,
  rfe_out_if.source         cipher_out
);

  logic          busy;
  logic          bank;
  logic [CW-1:0] count;
  logic [RW-1:0] rails_m1;
  logic [RW-1:0] rail;
  logic [PW-1:0] pos;
  logic          phase;
  logic [CW-1:0] emitted;
  logic          out_valid;
  logic          last_out;
  logic          in_range;
  logic          can_issue;
  logic          is_last;
  logic [RW:0]   step;

  assign cipher_out.valid       = out_valid;
  assign cipher_out.cipher_byte = rd_data;
  assign cipher_out.last_out    = last_out;

  // The RAM read register doubles as the output register.
  assign can_issue = !out_valid || cipher_out.ready;
  assign in_range  = (pos < PW'(count));
  assign rd_en     = busy && in_range && can_issue;
  assign rd_addr   = {bank, pos[AW-1:0]};
  assign is_last   = (CW'(emitted + CW'(1)) == count);
  assign job_done  = rd_en && is_last;
  assign pop       = !busy && job_valid;

  // Distance to the next position on this rail: a full period on the
  // outer rails, otherwise alternating down and up strokes.
  always_comb begin
    priority if ((rail == '0) || (rail == rails_m1)) begin
      step = {rails_m1, 1'b0};
    end else if (phase) begin
      step = {rail, 1'b0};
    end else begin
      step = {RW'(rails_m1 - rail), 1'b0};
    end
  end

  // Job load, rail walk and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && cipher_out.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy     <= 1'b1;
        bank     <= head_job.bank;
        count    <= CW'(head_job.count);
        rails_m1 <= RW'(head_job.rails_m1);
        rail     <= '0;
        pos      <= '0;
        phase    <= 1'b0;
        emitted  <= '0;
      end else if (busy) begin
        if (in_range) begin
          if (can_issue) begin
            out_valid <= 1'b1;
            last_out  <= is_last;
            emitted   <= emitted + CW'(1);
            pos       <= pos + PW'(step);
            phase     <= ~phase;
            if (is_last) begin
              busy <= 1'b0;
            end
          end
        end else begin
          // Rail exhausted: start the next one at its first position.
          rail  <= rail + RW'(1);
          pos   <= PW'(rail) + PW'(1);
          phase <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: test/rail_fence_encipher_unit_test.sv
// ----------------------------------------------------------------------------
// rail_fence_encipher_unit_test: self-checking bench for the rail fence unit
// Loads plaintext messages through the input channel and predicts the
// rail-major ciphertext of each one. Every ciphertext transaction is compared
// with the oldest prediction. The rail count goes through low, high and
// saturated settings. Both channels idle at random, and the receiver holds off
// long enough to fill both halves of the message store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rail_fence_encipher_unit_test;
  import rfe_pkg::*;

  localparam int MSG_DEPTH    = DEF_MESSAGE_DEPTH;
  localparam int RAIL_LIMIT   = DEF_MAX_RAILS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_WAIT    = 8;
  localparam int END_WAIT     = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_ITEMS = 16;

  // Receiver stall patterns.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic              last_out;
  } cipher_item_t;

  logic clk = 1'b0;
  logic rst;

  rfe_in_if  text_in ();
  rfe_out_if cipher_out ();
  rfe_cfg_if cfg ();

  rail_fence_encipher_unit #(
    .MESSAGE_DEPTH(MSG_DEPTH),
    .MAX_RAILS    (RAIL_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .cipher_out(cipher_out),
    .cfg       (cfg)
  );

  // Prediction state: plaintext of the open message, expected ciphertext.
  logic [BYTE_W-1:0]     plain_bytes[$];
  cipher_item_t          cipher_expected[$];
  logic [RAIL_CFG_W-1:0] rails_setting;

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_left;

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rail-major ciphertext of one message, appended to the expected results.
  function automatic void encipher_message(input logic [RAIL_CFG_W-1:0] setting);
    int unsigned rails;
    int unsigned period;
    int unsigned m;
    int unsigned zig;
    cipher_item_t item;
    rails = setting;
    if (rails < RAIL_COUNT_MIN) rails = RAIL_COUNT_MIN;
    if (rails > RAIL_LIMIT) rails = RAIL_LIMIT;
    period = 2 * (rails - 1);
    for (int unsigned r = 0; r < rails; r++) begin
      for (int unsigned p = 0; p < plain_bytes.size(); p++) begin
        m   = p % period;
        zig = (m < rails) ? m : period - m;
        if (zig == r) begin
          item.cipher_byte = plain_bytes[p];
          item.last_out    = 1'b0;
          cipher_expected.push_back(item);
        end
      end
    end
    cipher_expected[cipher_expected.size() - 1].last_out = 1'b1;
    plain_bytes.delete();
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch in %s at cycle %0d: expected %0h, actual %0h",
               what, cycle_count, want, got);
  endfunction

  // Watch all three channels at each edge: update the prediction on input and
  // configuration transactions, and check every ciphertext transaction.
  always @(posedge clk) begin
    cipher_item_t want;
    if (rst) begin
      rails_setting <= RAIL_COUNT_RESET;
      plain_bytes.delete();
      cipher_expected.delete();
    end else begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("rail_fence_encipher_unit_test failed");
        $finish;
      end else begin
        if (cfg.valid && cfg.ready)
          rails_setting <= cfg.rail_count;
        if (text_in.valid && text_in.ready) begin
          if (plain_bytes.size() < MSG_DEPTH)
            plain_bytes.push_back(text_in.text_byte);
          if (text_in.end_of_message)
            encipher_message(rails_setting);
        end
        if (cipher_out.valid && cipher_out.ready) begin
          if (cipher_expected.size() == 0) begin
            note_mismatch("unexpected transaction", 0, cipher_out.cipher_byte);
          end else begin
            want = cipher_expected.pop_front();
            if (cipher_out.cipher_byte !== want.cipher_byte)
              note_mismatch("cipher_byte", want.cipher_byte, cipher_out.cipher_byte);
            if (cipher_out.last_out !== want.last_out)
              note_mismatch("last_out", want.last_out, cipher_out.last_out);
          end
        end
      end
    end
  end

  // Receiver: a long hold when asked, otherwise a stall pattern that is
  // picked anew at random after a run of random length.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned phase;
    cipher_out.ready <= 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        cipher_out.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS:   cipher_out.ready <= 1'b1;
          RX_RANDOM:   cipher_out.ready <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC: cipher_out.ready <= (phase % 4 != 0);
          default:     cipher_out.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one plaintext byte and wait for its transaction; bursts of random
  // length are separated by random gaps when gaps are enabled.
  task automatic send_text(input logic [BYTE_W-1:0] value, input logic eom);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        text_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    text_in.valid          <= 1'b1;
    text_in.text_byte      <= value;
    text_in.end_of_message <= eom;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_text(BYTE_W'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Stop offering input and wait until every expected byte has come out.
  task automatic wait_drained();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (cipher_expected.size() != 0 || plain_bytes.size() != 0) @(posedge clk);
  endtask

  // Rail count is written only while the unit is idle.
  task automatic set_rails(input logic [RAIL_CFG_W-1:0] value);
    wait_drained();
    repeat (IDLE_WAIT) @(posedge clk);
    cfg.valid      <= 1'b1;
    cfg.rail_count <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RAIL_CFG_W-1:0] pick_rails();
    case ($urandom_range(0, 5))
      0:       return RAIL_CFG_W'($urandom_range(0, 1));
      1:       return RAIL_COUNT_MIN;
      2:       return RAIL_CFG_W'(RAIL_LIMIT);
      3:       return RAIL_CFG_W'($urandom_range(RAIL_LIMIT + 1, 63));
      default: return RAIL_CFG_W'($urandom_range(RAIL_COUNT_MIN, RAIL_LIMIT - 1));
    endcase
  endfunction

  // Reset rail count of three, with extreme byte values.
  task automatic test_default_rails();
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h55, 1'b0);
    send_text(8'hAA, 1'b0);
    send_text(8'h01, 1'b1);
  endtask

  // A message of one byte is its own ciphertext and carries the last mark.
  task automatic test_single_byte_message();
    send_text(8'h80, 1'b1);
    wait_drained();
  endtask

  // Rail counts of zero and one act as two.
  task automatic test_rail_clamp_low();
    set_rails(6'd0);
    send_text(8'h11, 1'b0);
    send_text(8'h22, 1'b0);
    send_text(8'h33, 1'b0);
    send_text(8'h44, 1'b1);
    set_rails(6'd1);
    send_text(8'hFE, 1'b0);
    send_text(8'h7F, 1'b0);
    send_text(8'h01, 1'b1);
  endtask

  // Rail counts above the maximum saturate; the maximum itself is exact.
  task automatic test_rail_saturate_high();
    set_rails(6'd63);
    send_text(8'hC3, 1'b0);
    send_text(8'h3C, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h5A, 1'b1);
    set_rails(RAIL_CFG_W'(RAIL_LIMIT));
    send_text(8'h0F, 1'b0);
    send_text(8'hF0, 1'b0);
    send_text(8'h99, 1'b1);
  endtask

  // Bytes past the store capacity are dropped, and so is the end-marked byte,
  // which still closes the message.
  task automatic test_store_overflow();
    set_rails(RAIL_COUNT_MIN);
    send_message(MSG_DEPTH + 2);
  endtask

  // A long receiver hold fills both store halves and stalls the input; then
  // the sender pauses until everything has come out before one more message.
  task automatic test_backpressure();
    set_rails(pick_rails());
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (3) send_message(6);
    wait_drained();
    send_message(4);
    gaps_on = 1'b1;
  endtask

  // Random messages under changing rail counts and idling.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      set_rails(pick_rails());
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 12);
        send_message(len);
        sent += len;
      end
    end
  endtask

  // Reset, the tests in turn, then the final drain and verdict.
  initial begin
    rst                    <= 1'b1;
    text_in.valid          <= 1'b0;
    text_in.text_byte      <= '0;
    text_in.end_of_message <= 1'b0;
    cfg.valid              <= 1'b0;
    cfg.rail_count         <= '0;
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    gaps_on     = 1'b0;
    hold_left   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_rails();
    test_single_byte_message();
    test_rail_clamp_low();
    test_rail_saturate_high();
    gaps_on = 1'b1;
    test_store_overflow();
    test_backpressure();
    test_random_messages();

    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("rail_fence_encipher_unit_test passed");
    end else begin
      $display("rail_fence_encipher_unit_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rfe_pkg.sv
rtl/core/rfe_if.sv
rtl/core/rfe_ram.sv
rtl/core/rfe_job_queue.sv
rtl/core/rfe_front.sv
rtl/core/rfe_back.sv
rtl/core/rail_fence_encipher_unit.sv
test/rail_fence_encipher_unit_test.sv
